// ===== design/ssst_pkg.sv =====
// Shared constants, types and sequencer states for the sample set statistics block.
`default_nettype none
package ssst_pkg;

  localparam int SET_SIZE = 10;
  localparam int LOG_N    = $clog2(SET_SIZE);
  localparam int CNT_W    = LOG_N;
  localparam int SMP_W    = 16;
  localparam int SUM_W    = SMP_W + LOG_N;
  localparam int SQ_W     = 2 * SMP_W - 1 + LOG_N;
  localparam int NUM_W    = 2 * SMP_W - 1 + 2 * LOG_N;
  localparam int ROOT_W   = (NUM_W + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int ALU_W    = ROOT_W + 4;
  localparam int STEP_W   = $clog2(ROOT_W);
  localparam int MDV_W    = SUM_W + 1;
  localparam int DIV_MEAN = 2 * SET_SIZE;
  localparam int MEAN_K   = SUM_W + LOG_N + 2;
  localparam int MEAN_MW  = SUM_W + 3;
  localparam int MPROD_W  = MDV_W + MEAN_MW;
  localparam longint MEAN_MUL = ((longint'(1) << MEAN_K) + DIV_MEAN - 1) / DIV_MEAN;
  localparam int SD_K     = ROOT_W + LOG_N;
  localparam int SD_MW    = ROOT_W + 2;
  localparam int SPROD_W  = ROOT_W + SD_MW;
  localparam longint SD_MUL = ((longint'(1) << SD_K) + SET_SIZE - 1) / SET_SIZE;

  typedef logic signed [SMP_W-1:0] smp_t;

  localparam smp_t MIN_INIT = {1'b0, {(SMP_W-1){1'b1}}};
  localparam smp_t MAX_INIT = {1'b1, {(SMP_W-1){1'b0}}};

  typedef struct packed {
    smp_t                    minimum;
    smp_t                    maximum;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq_sum;
  } acc_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    smp_t             mean;
    logic [SMP_W-1:0] std_dev;
  } seq_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_PROD,
    ST_DIVM,
    ST_DIVV,
    ST_SQRT,
    ST_DONE
  } seq_state_t;

endpackage
`default_nettype wire

// ===== design/ssst_accum.sv =====
// Per-set accumulator: sample count, running extremes, sum and sum of squares.
`default_nettype none
module ssst_accum (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           clr,
  input  wire ssst_pkg::smp_t sample,
  output ssst_pkg::acc_t      acc,
  output logic                last
);
  import ssst_pkg::*;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  smp_t                    min_r, min_nxt;
  smp_t                    max_r, max_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic [SMP_W-1:0]        mag;
  logic [2*SMP_W-1:0]      sq;

  assign mag  = sample[SMP_W-1] ? $unsigned(-sample) : $unsigned(sample);
  assign sq   = mag * mag;
  assign last = (cnt_r >= CNT_W'(SET_SIZE - 1));

  always_comb begin
    cnt_nxt = cnt_r;
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    if (clr) begin
      cnt_nxt = '0;
      min_nxt = MIN_INIT;
      max_nxt = MAX_INIT;
      sum_nxt = '0;
      sq_nxt  = '0;
    end else if (en) begin
      if (sample < min_r) begin
        min_nxt = sample;
      end
      if (sample > max_r) begin
        max_nxt = sample;
      end
      sum_nxt = sum_r + SUM_W'(sample);
      sq_nxt  = sq_r + SQ_W'(sq);
      cnt_nxt = last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      min_r <= MIN_INIT;
      max_r <= MAX_INIT;
      sum_r <= '0;
      sq_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
    end
  end

  assign acc.minimum = min_r;
  assign acc.maximum = max_r;
  assign acc.sum     = sum_r;
  assign acc.sq_sum  = sq_r;

endmodule
`default_nettype wire

// ===== design/ssst_alu.sv =====
// Shared compare-subtract unit for the square root steps.
`default_nettype none
module ssst_alu (
  input  wire logic [ssst_pkg::ALU_W-1:0] a,
  input  wire logic [ssst_pkg::ALU_W-1:0] b,
  output logic                            ge,
  output logic [ssst_pkg::ALU_W-1:0]      diff
);
  import ssst_pkg::*;

  logic [ALU_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[ALU_W];
  assign diff = wide[ALU_W-1:0];

endmodule
`default_nettype wire

// ===== design/ssst_seq.sv =====
// Result sequencer: rounded mean by reciprocal multiply, deviation by repeated steps of the shared unit.
`default_nettype none
module ssst_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           load,
  input  wire ssst_pkg::acc_t acc,
  output ssst_pkg::seq_stat_t stat,
  output ssst_pkg::seq_res_t  res,
  output logic                clr
);
  import ssst_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [NUM_W-1:0]  sqm_r, sqm_nxt;
  logic [NUM_W-1:0]  ns2_r, ns2_nxt;
  logic [MDV_W-1:0]  dvd_r, dvd_nxt;
  logic [ALU_W-1:0]  rem_r, rem_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  smp_t              mean_r, mean_nxt;
  logic [SMP_W-1:0]  sd_r, sd_nxt;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
  logic               alu_ge;
  logic [2*SUM_W-1:0] msq;
  logic [NUM_W-1:0]   num;
  logic [MDV_W-1:0]   mdvd;
  logic [MPROD_W-1:0] mprod;
  logic [SPROD_W-1:0] sprod;
  logic [SMP_W-1:0]   qm;
  logic [SMP_W-1:0]   qs;

  ssst_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  assign msq   = mag_r * mag_r;
  assign num   = (ns2_r >= sqm_r) ? ns2_r - sqm_r : '0;
  assign mdvd  = {mag_r, 1'b0} + MDV_W'(SET_SIZE);
  assign mprod = MPROD_W'(dvd_r) * MPROD_W'(MEAN_MUL);
  assign qm    = mprod[MEAN_K +: SMP_W];
  assign sprod = SPROD_W'(root_r) * SPROD_W'(SD_MUL);
  assign qs    = sprod[SD_K +: SMP_W];
  assign alu_a = {rem_r[ALU_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign alu_b = ALU_W'({root_r, 2'b01});

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    sqm_nxt   = sqm_r;
    ns2_nxt   = ns2_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    mean_nxt  = mean_r;
    sd_nxt    = sd_r;
    clr       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        neg_nxt   = acc.sum[SUM_W-1];
        mag_nxt   = acc.sum[SUM_W-1] ? $unsigned(-acc.sum) : $unsigned(acc.sum);
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        sqm_nxt   = NUM_W'(msq);
        ns2_nxt   = NUM_W'(acc.sq_sum) * NUM_W'(SET_SIZE);
        dvd_nxt   = mdvd;
        state_nxt = ST_DIVM;
      end
      ST_DIVM: begin
        mean_nxt  = neg_r ? $signed(-qm) : $signed(qm);
        rad_nxt   = RAD_W'(num);
        rem_nxt   = '0;
        root_nxt  = '0;
        step_nxt  = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        rem_nxt  = alu_ge ? alu_diff : alu_a;
        root_nxt = {root_r[ROOT_W-2:0], alu_ge};
        rad_nxt  = rad_r << 2;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_DIVV;
        end
      end
      ST_DIVV: begin
        sd_nxt    = qs;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          clr       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    sqm_r  <= sqm_nxt;
    ns2_r  <= ns2_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    mean_r <= mean_nxt;
    sd_r   <= sd_nxt;
  end

  assign stat.idle   = (state_r == ST_IDLE);
  assign stat.done   = (state_r == ST_DONE);
  assign res.mean    = mean_r;
  assign res.std_dev = sd_r;

endmodule
`default_nettype wire

// ===== design/sample_set_statistics.sv =====
// Sample set statistics top level: min, max, rounded mean and deviation per set of samples.
// Samples other than the last of a set are taken one per cycle; the last starts the sequencer,
// mostly a ROOT_W-step square root on one shared unit. The input stalls meanwhile, and longer
// while a stalled output item blocks it. Synchronous active-low reset clears the set and drops
// any pending result.
`default_nettype none
module sample_set_statistics (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic signed [15:0] in_sample,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic signed [15:0]  out_minimum,
  output logic signed [15:0]  out_maximum,
  output logic signed [15:0]  out_mean,
  output logic [15:0]         out_std_dev
);
  import ssst_pkg::*;

  acc_t      acc;
  seq_stat_t stat;
  seq_res_t  res;
  logic      accept, last, clr, load;

  logic             out_valid_r, out_valid_nxt;
  smp_t             min_r, max_r, mean_r;
  logic [SMP_W-1:0] sd_r;

  assign in_stall = ~stat.idle;
  assign accept   = in_valid & ~in_stall;
  assign load     = stat.done & (~out_valid_r | ~out_stall);

  ssst_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .clr    (clr),
    .sample (in_sample),
    .acc    (acc),
    .last   (last)
  );

  ssst_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept & last),
    .load  (load),
    .acc   (acc),
    .stat  (stat),
    .res   (res),
    .clr   (clr)
  );

  assign out_valid_nxt = load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      min_r  <= acc.minimum;
      max_r  <= acc.maximum;
      mean_r <= res.mean;
      sd_r   <= res.std_dev;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_minimum = min_r;
  assign out_maximum = max_r;
  assign out_mean    = mean_r;
  assign out_std_dev = sd_r;

endmodule
`default_nettype wire

// ===== design/ssst_checker.sv =====
// Port checker for the sample set statistics block, with its bind.
`default_nettype none
module ssst_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [15:0] in_sample,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_minimum,
  input wire logic signed [15:0] out_maximum,
  input wire logic signed [15:0] out_mean,
  input wire logic [15:0]        out_std_dev
);

  logic signed [16:0] span;

  assign span = 17'(out_maximum) - 17'(out_minimum);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mean) && $stable(out_std_dev))
    else $error("stalled result item changed");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_minimum <= out_maximum)
    else $error("minimum above maximum");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean >= out_minimum) && (out_mean <= out_maximum))
    else $error("mean outside sample range");

  a_dev_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_std_dev} + {1'b0, out_std_dev} <= $unsigned(span))
    else $error("deviation exceeds half the range");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared while input was open");

endmodule

bind sample_set_statistics ssst_checker u_ssst_checker (.*);
`default_nettype wire
